>>> rtl/cds_pkg.sv
// Shared widths, latencies and side-band types for the Smith complex divider.
`default_nettype none
package cds_pkg;
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int RATIO_BITS = DATA_WIDTH - 2;

    localparam int MAG_W     = DATA_WIDTH;
    localparam int RATIO_W   = RATIO_BITS + 1;
    localparam int RATIO_S_W = RATIO_BITS + 2;
    localparam int SQ_W      = 2 * RATIO_W;
    localparam int OPS_W     = RATIO_BITS + 2;
    localparam int DEN_S_W   = DATA_WIDTH + OPS_W + 1;
    localparam int DEN_W     = DATA_WIDTH + RATIO_BITS + 1;
    localparam int NUM_S_W   = DATA_WIDTH + RATIO_BITS + 2;
    localparam int NUM_W     = DATA_WIDTH + RATIO_BITS + 1;
    localparam int QUOT_W    = DATA_WIDTH + 1;
    localparam int WIDE_W    = NUM_W + FRAC_BITS;

    localparam int RATIO_LAT = RATIO_W + 1;
    localparam int SCALE_LAT = 5;
    localparam int QUOT_LAT  = QUOT_W + 2;
    localparam int LATENCY   = RATIO_LAT + SCALE_LAT + QUOT_LAT;

    typedef struct packed {
        logic                         zero;
        logic                         im_pivot;
        logic                         neg_ratio;
        logic signed [DATA_WIDTH-1:0] zr;
        logic signed [DATA_WIDTH-1:0] zi;
        logic signed [DATA_WIDTH-1:0] pivot;
    } t_side;

    typedef struct packed {
        logic zero;
        logic neg_r;
        logic neg_i;
    } t_qside;
endpackage
`default_nettype wire

>>> rtl/complex_divide_smith.sv
// Top level of the pipelined Smith complex divider.
// Fully pipelined: one beat may enter every clock, busy is always low, and each
// result appears on o_valid after pivot select and ratio division at one bit per
// stage, then squaring, products and magnitudes, then quotient division at one
// bit per stage plus saturation. The receiver cannot stall, so a result is
// shown for one cycle only and must be captured then.
`default_nettype none
module complex_divide_smith (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [cds_pkg::DATA_WIDTH-1:0] i_dividend_real,
    input  wire logic signed [cds_pkg::DATA_WIDTH-1:0] i_dividend_imag,
    input  wire logic signed [cds_pkg::DATA_WIDTH-1:0] i_divisor_real,
    input  wire logic signed [cds_pkg::DATA_WIDTH-1:0] i_divisor_imag,
    output logic                                       o_valid,
    output logic signed [cds_pkg::DATA_WIDTH-1:0]      o_quotient_real,
    output logic signed [cds_pkg::DATA_WIDTH-1:0]      o_quotient_imag,
    output logic                                       o_saturated_flag,
    output logic                                       o_zero_divisor_flag
);
    import cds_pkg::*;

    logic               rat_vld;
    logic [RATIO_W-1:0] rat_rm;
    t_side              rat_side;
    logic               scl_vld;
    logic [NUM_W-1:0]   scl_nr, scl_ni;
    logic [DEN_W-1:0]   scl_d;
    t_qside             scl_qs;
    logic [DATA_WIDTH-1:0] qr, qi;

    assign busy = 1'b0;

    cds_ratio_div u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start && !busy),
        .i_zr    (i_dividend_real),
        .i_zi    (i_dividend_imag),
        .i_dr    (i_divisor_real),
        .i_di    (i_divisor_imag),
        .o_valid (rat_vld),
        .o_rm    (rat_rm),
        .o_side  (rat_side)
    );

    cds_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (rat_vld),
        .i_rm     (rat_rm),
        .i_side   (rat_side),
        .o_valid  (scl_vld),
        .o_nmag_r (scl_nr),
        .o_nmag_i (scl_ni),
        .o_dmag   (scl_d),
        .o_qside  (scl_qs)
    );

    cds_quot_div u_quot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (scl_vld),
        .i_nmag_r (scl_nr),
        .i_nmag_i (scl_ni),
        .i_dmag   (scl_d),
        .i_qside  (scl_qs),
        .o_valid  (o_valid),
        .o_qr     (qr),
        .o_qi     (qi),
        .o_sat    (o_saturated_flag),
        .o_zero   (o_zero_divisor_flag)
    );

    assign o_quotient_real = $signed(qr);
    assign o_quotient_imag = $signed(qi);
endmodule
`default_nettype wire

>>> rtl/cds_ratio_div.sv
// Pivot selection and pipelined restoring divider for the ratio other/pivot.
`default_nettype none
module cds_ratio_div (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [cds_pkg::DATA_WIDTH-1:0] i_zr,
    input  wire logic signed [cds_pkg::DATA_WIDTH-1:0] i_zi,
    input  wire logic signed [cds_pkg::DATA_WIDTH-1:0] i_dr,
    input  wire logic signed [cds_pkg::DATA_WIDTH-1:0] i_di,
    output logic                                       o_valid,
    output logic [cds_pkg::RATIO_W-1:0]                o_rm,
    output cds_pkg::t_side                             o_side
);
    import cds_pkg::*;

    logic             r_vld  [0:RATIO_W];
    logic [MAG_W-1:0] r_rem  [0:RATIO_W];
    logic [MAG_W-1:0] r_pm   [0:RATIO_W];
    logic [RATIO_W-1:0] r_q  [0:RATIO_W];
    t_side            r_side [0:RATIO_W];

    logic [MAG_W-1:0] ar, ai, pmag, omag;
    logic             im_piv;
    t_side            n_side;

    always_comb begin
        ar     = i_dr[DATA_WIDTH-1] ? MAG_W'(~i_dr + 1'b1) : MAG_W'(i_dr);
        ai     = i_di[DATA_WIDTH-1] ? MAG_W'(~i_di + 1'b1) : MAG_W'(i_di);
        im_piv = (ar <= ai);
        pmag   = im_piv ? ai : ar;
        omag   = im_piv ? ar : ai;
        n_side.zero      = (i_dr == '0) && (i_di == '0);
        n_side.im_pivot  = im_piv;
        n_side.neg_ratio = i_dr[DATA_WIDTH-1] ^ i_di[DATA_WIDTH-1];
        n_side.zr        = i_zr;
        n_side.zi        = i_zi;
        n_side.pivot     = im_piv ? i_di : i_dr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_start;
        end
        r_rem[0]  <= omag;
        r_pm[0]   <= pmag;
        r_q[0]    <= '0;
        r_side[0] <= n_side;
    end

    // one quotient bit per stage, MSB first; the first stage takes no shift
    for (genvar k = 0; k < RATIO_W; k++) begin : g_stage
        logic [MAG_W:0]     trial;
        logic               ge;
        logic [MAG_W-1:0]   n_rem;
        logic [RATIO_W-1:0] n_q;

        always_comb begin
            trial = (k == 0) ? {1'b0, r_rem[k]} : {r_rem[k], 1'b0};
            ge    = (trial >= {1'b0, r_pm[k]});
            n_rem = ge ? MAG_W'(trial - {1'b0, r_pm[k]}) : MAG_W'(trial);
            n_q   = {r_q[k][RATIO_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rem[k+1]  <= n_rem;
            r_pm[k+1]   <= r_pm[k];
            r_q[k+1]    <= n_q;
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_vld[RATIO_W];
    assign o_rm    = r_q[RATIO_W];
    assign o_side  = r_side[RATIO_W];
endmodule
`default_nettype wire

>>> rtl/cds_scale.sv
// Denominator and numerator forming: square, scale products, sums and magnitudes.
`default_nettype none
module cds_scale (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [cds_pkg::RATIO_W-1:0] i_rm,
    input  wire cds_pkg::t_side           i_side,
    output logic                          o_valid,
    output logic [cds_pkg::NUM_W-1:0]     o_nmag_r,
    output logic [cds_pkg::NUM_W-1:0]     o_nmag_i,
    output logic [cds_pkg::DEN_W-1:0]     o_dmag,
    output cds_pkg::t_qside               o_qside
);
    import cds_pkg::*;

    localparam logic [OPS_W-1:0] ONE = OPS_W'(1) << RATIO_BITS;

    // stage 1: ratio square and signed ratio
    logic                        r1_vld;
    logic [SQ_W-1:0]             r1_sq;
    logic signed [RATIO_S_W-1:0] r1_ratio;
    t_side                       r1_side;
    // stage 2: one plus square
    logic                        r2_vld;
    logic [OPS_W-1:0]            r2_ops;
    logic signed [RATIO_S_W-1:0] r2_ratio;
    t_side                       r2_side;
    // stage 3: products
    logic                        r3_vld;
    logic signed [DEN_S_W-1:0]   r3_den;
    logic signed [NUM_S_W-1:0]   r3_pa, r3_pb;
    t_side                       r3_side;
    // stage 4: numerator sums and denominator magnitude
    logic                        r4_vld;
    logic signed [NUM_S_W-1:0]   r4_nr, r4_ni;
    logic [DEN_W-1:0]            r4_dmag;
    t_qside                      r4_qs;
    // stage 5: magnitudes
    logic                        r5_vld;
    logic [NUM_W-1:0]            r5_nr, r5_ni;
    logic [DEN_W-1:0]            r5_dmag;
    t_qside                      r5_qs;

    logic signed [RATIO_S_W-1:0] n_ratio;
    logic signed [NUM_S_W-1:0]   zr_sh, zi_sh, n_nr, n_ni;
    logic signed [DEN_S_W-1:0]   den_abs;
    t_qside                      n_qs;

    always_comb begin
        n_ratio = i_side.neg_ratio ? -$signed({1'b0, i_rm}) : $signed({1'b0, i_rm});
        zr_sh   = NUM_S_W'(r3_side.zr) <<< RATIO_BITS;
        zi_sh   = NUM_S_W'(r3_side.zi) <<< RATIO_BITS;
        if (r3_side.im_pivot) begin
            n_nr = r3_pa + zi_sh;
            n_ni = r3_pb - zr_sh;
        end else begin
            n_nr = zr_sh + r3_pb;
            n_ni = zi_sh - r3_pa;
        end
        den_abs    = r3_den[DEN_S_W-1] ? -r3_den : r3_den;
        n_qs.zero  = r3_side.zero;
        n_qs.neg_r = n_nr[NUM_S_W-1] ^ r3_side.pivot[DATA_WIDTH-1];
        n_qs.neg_i = n_ni[NUM_S_W-1] ^ r3_side.pivot[DATA_WIDTH-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
        r1_sq    <= SQ_W'(i_rm) * SQ_W'(i_rm);
        r1_ratio <= n_ratio;
        r1_side  <= i_side;

        r2_ops   <= ONE + OPS_W'(r1_sq >> RATIO_BITS);
        r2_ratio <= r1_ratio;
        r2_side  <= r1_side;

        r3_den   <= DEN_S_W'(r2_side.pivot) * $signed({1'b0, r2_ops});
        r3_pa    <= NUM_S_W'(r2_side.zr) * NUM_S_W'(r2_ratio);
        r3_pb    <= NUM_S_W'(r2_side.zi) * NUM_S_W'(r2_ratio);
        r3_side  <= r2_side;

        r4_nr    <= n_nr;
        r4_ni    <= n_ni;
        r4_dmag  <= DEN_W'(den_abs);
        r4_qs    <= n_qs;

        r5_nr    <= r4_nr[NUM_S_W-1] ? NUM_W'(-r4_nr) : NUM_W'(r4_nr);
        r5_ni    <= r4_ni[NUM_S_W-1] ? NUM_W'(-r4_ni) : NUM_W'(r4_ni);
        r5_dmag  <= r4_dmag;
        r5_qs    <= r4_qs;
    end

    assign o_valid  = r5_vld;
    assign o_nmag_r = r5_nr;
    assign o_nmag_i = r5_ni;
    assign o_dmag   = r5_dmag;
    assign o_qside  = r5_qs;
endmodule
`default_nettype wire

>>> rtl/cds_quot_div.sv
// Two-lane pipelined quotient divider with saturation and output register.
`default_nettype none
module cds_quot_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [cds_pkg::NUM_W-1:0]    i_nmag_r,
    input  wire logic [cds_pkg::NUM_W-1:0]    i_nmag_i,
    input  wire logic [cds_pkg::DEN_W-1:0]    i_dmag,
    input  wire cds_pkg::t_qside              i_qside,
    output logic                              o_valid,
    output logic [cds_pkg::DATA_WIDTH-1:0]    o_qr,
    output logic [cds_pkg::DATA_WIDTH-1:0]    o_qi,
    output logic                              o_sat,
    output logic                              o_zero
);
    import cds_pkg::*;

    localparam logic [QUOT_W-1:0] LIM_POS = (QUOT_W'(1) << (DATA_WIDTH - 1)) - 1'b1;
    localparam logic [QUOT_W-1:0] LIM_NEG = QUOT_W'(1) << (DATA_WIDTH - 1);

    logic              r_vld [0:QUOT_W];
    logic [DEN_W-1:0]  r_d   [0:QUOT_W];
    t_qside            r_qs  [0:QUOT_W];
    logic [DEN_W-1:0]  r_rem [0:QUOT_W][0:1];
    logic [QUOT_W-1:0] r_low [0:QUOT_W][0:1];
    logic [QUOT_W-1:0] r_q   [0:QUOT_W][0:1];
    logic              r_ovf [0:QUOT_W][0:1];

    logic [WIDE_W-1:0] wide [0:1];
    logic [NUM_W-1:0]  nin  [0:1];

    assign nin[0] = i_nmag_r;
    assign nin[1] = i_nmag_i;

    // the quotient holds QUOT_W bits; anything at or above 2^QUOT_W is flagged up front
    for (genvar l = 0; l < 2; l++) begin : g_lane_in
        assign wide[l] = WIDE_W'(nin[l]) << FRAC_BITS;
        always_ff @(posedge i_clk) begin
            r_rem[0][l] <= DEN_W'(wide[l] >> QUOT_W);
            r_low[0][l] <= wide[l][QUOT_W-1:0];
            r_q[0][l]   <= '0;
            r_ovf[0][l] <= ((wide[l] >> QUOT_W) >= WIDE_W'(i_dmag));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_d[0]  <= i_dmag;
        r_qs[0] <= i_qside;
    end

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_d[k+1]  <= r_d[k];
            r_qs[k+1] <= r_qs[k];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DEN_W:0] trial;
            logic           ge;

            always_comb begin
                trial = {r_rem[k][l], r_low[k][l][QUOT_W-1]};
                ge    = (trial >= {1'b0, r_d[k]});
            end

            always_ff @(posedge i_clk) begin
                r_rem[k+1][l] <= ge ? DEN_W'(trial - {1'b0, r_d[k]}) : DEN_W'(trial);
                r_low[k+1][l] <= {r_low[k][l][QUOT_W-2:0], 1'b0};
                r_q[k+1][l]   <= {r_q[k][l][QUOT_W-2:0], ge};
                r_ovf[k+1][l] <= r_ovf[k][l];
            end
        end
    end

    logic [QUOT_W-1:0]     lim [0:1];
    logic [QUOT_W-1:0]     qc  [0:1];
    logic [DATA_WIDTH-1:0] qs  [0:1];
    logic                  sat [0:1];
    logic                  neg [0:1];

    assign neg[0] = r_qs[QUOT_W].neg_r;
    assign neg[1] = r_qs[QUOT_W].neg_i;

    for (genvar l = 0; l < 2; l++) begin : g_lane_out
        always_comb begin
            lim[l] = neg[l] ? LIM_NEG : LIM_POS;
            sat[l] = r_ovf[QUOT_W][l] || (r_q[QUOT_W][l] > lim[l]);
            qc[l]  = sat[l] ? lim[l] : r_q[QUOT_W][l];
            qs[l]  = neg[l] ? DATA_WIDTH'(-qc[l]) : DATA_WIDTH'(qc[l]);
        end
    end

    logic                  r_out_vld, r_sat, r_zero;
    logic [DATA_WIDTH-1:0] r_qr, r_qi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[QUOT_W];
        end
        r_zero <= r_qs[QUOT_W].zero;
        r_sat  <= !r_qs[QUOT_W].zero && (sat[0] || sat[1]);
        r_qr   <= r_qs[QUOT_W].zero ? '0 : qs[0];
        r_qi   <= r_qs[QUOT_W].zero ? '0 : qs[1];
    end

    assign o_valid = r_out_vld;
    assign o_qr    = r_qr;
    assign o_qi    = r_qi;
    assign o_sat   = r_sat;
    assign o_zero  = r_zero;
endmodule
`default_nettype wire

>>> rtl/cds_checker.sv
// Port-level checks for the Smith complex divider, bound to the top level.
`default_nettype none
module cds_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  start,
    input wire logic                                  busy,
    input wire logic signed [cds_pkg::DATA_WIDTH-1:0] i_divisor_real,
    input wire logic signed [cds_pkg::DATA_WIDTH-1:0] i_divisor_imag,
    input wire logic                                  o_valid,
    input wire logic signed [cds_pkg::DATA_WIDTH-1:0] o_quotient_real,
    input wire logic signed [cds_pkg::DATA_WIDTH-1:0] o_quotient_imag,
    input wire logic                                  o_saturated_flag,
    input wire logic                                  o_zero_divisor_flag
);
    import cds_pkg::*;

    a_no_busy: assert property (@(posedge i_clk) busy == 1'b0)
        else $error("busy raised on a fully pipelined block");

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_divisor_flag |->
            o_quotient_real == '0 && o_quotient_imag == '0 && !o_saturated_flag)
        else $error("zero divisor result not cleared");

    a_zero_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_divisor_real == '0 && i_divisor_imag == '0 |->
            ##LATENCY (o_valid && o_zero_divisor_flag))
        else $error("zero divisor beat lost or late");
endmodule

bind complex_divide_smith cds_checker u_cds_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .i_divisor_real      (i_divisor_real),
    .i_divisor_imag      (i_divisor_imag),
    .o_valid             (o_valid),
    .o_quotient_real     (o_quotient_real),
    .o_quotient_imag     (o_quotient_imag),
    .o_saturated_flag    (o_saturated_flag),
    .o_zero_divisor_flag (o_zero_divisor_flag)
);
`default_nettype wire
